@@ rtl/ssms_pkg.sv @@
// shared types and constants of the solid source mesh size pipeline
package ssms_pkg;

	// coordinate format
	localparam int COORD_W = 20;
	localparam int PACK_W  = 3 * COORD_W;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int MD_W    = 43;
	localparam int SQ_W    = 40;
	localparam int DD_W    = 42;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_C = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GROWTH = 3'd6;

	// source modes
	localparam logic [1:0] MODE_SURFACE   = 2'd0;
	localparam logic [1:0] MODE_CUBOID    = 2'd1;
	localparam logic [1:0] MODE_ELLIPSOID = 2'd2;

	localparam logic [15:0] GROWTH_ONE = 16'd4096;

	// side data that travels with each request through the pipeline
	typedef struct packed {
		logic                      vld;
		logic                      fault;
		logic                      big;
		logic [2:0]                gt;
		logic [2:0][MD_W-1:0]      md;
		logic [2:0][SQ_W-1:0]      sq;
		logic [DD_W-1:0]           dd;
		logic [31:0]               m;
		logic [31:0]               root;
	} side_t;

endpackage

@@ rtl/ssms_isqrt.sv @@
// pipelined floor square root, 64-bit operand, one result bit per stage
module ssms_isqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [63:0]      op,
	input  ssms_pkg::side_t  tag_in,
	output logic [31:0]      root,
	output ssms_pkg::side_t  tag_out
);
	import ssms_pkg::*;

	logic [63:0] rem_st [0:32];
	logic [63:0] res_st [0:32];
	side_t       tag_st [0:32];

	assign rem_st[0] = op;
	assign res_st[0] = '0;
	assign tag_st[0] = tag_in;

	// one digit step per stage
	for (genvar j = 0; j < 32; j++) begin : g_step
		logic [63:0] bitv;
		logic [63:0] trial;
		logic        take;
		assign bitv  = 64'd1 << (62 - 2 * j);
		assign trial = res_st[j] + bitv;
		assign take  = rem_st[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_st[j+1] <= '0;
			end else if (en) begin
				tag_st[j+1] <= tag_st[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[j+1] <= take ? rem_st[j] - trial : rem_st[j];
				res_st[j+1] <= take ? (res_st[j] >> 1) + bitv : res_st[j] >> 1;
			end
		end
	end

	assign root    = res_st[32][31:0];
	assign tag_out = tag_st[32];

endmodule

@@ rtl/ssms_div.sv @@
// pipelined restoring divider, 64-bit by 48-bit, 32 quotient bits and overflow flag
module ssms_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [63:0]      num,
	input  logic [47:0]      den,
	input  ssms_pkg::side_t  tag_in,
	output logic [31:0]      quo,
	output logic             ovf,
	output ssms_pkg::side_t  tag_out
);
	import ssms_pkg::*;

	logic [63:0] rem_st [0:32];
	logic [47:0] den_st [0:32];
	logic [31:0] quo_st [0:32];
	logic        ovf_st [0:32];
	side_t       tag_st [0:32];

	// quotient needs more than 32 bits when num >= den * 2^32
	assign rem_st[0] = num;
	assign den_st[0] = den;
	assign quo_st[0] = '0;
	assign ovf_st[0] = {16'd0, num[63:32]} >= den;
	assign tag_st[0] = tag_in;

	// one quotient bit per stage, msb first
	for (genvar j = 0; j < 32; j++) begin : g_step
		logic [79:0] trial;
		logic        take;
		assign trial = {32'd0, den_st[j]} << (31 - j);
		assign take  = {16'd0, rem_st[j]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_st[j+1] <= '0;
			end else if (en) begin
				tag_st[j+1] <= tag_st[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[j+1] <= take ? rem_st[j] - trial[63:0] : rem_st[j];
				den_st[j+1] <= den_st[j];
				quo_st[j+1] <= {quo_st[j][30:0], take};
				ovf_st[j+1] <= ovf_st[j];
			end
		end
	end

	assign quo     = quo_st[32];
	assign ovf     = ovf_st[32];
	assign tag_out = tag_st[32];

endmodule

@@ rtl/ssms_front.sv @@
// front stages: offset from origin, dot products, squared lengths, fault check
module ssms_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_vld,
	input  logic [ssms_pkg::PACK_W-1:0]             point,
	input  logic [ssms_pkg::PACK_W-1:0]             origin,
	input  logic [2:0][ssms_pkg::PACK_W-1:0]        axis,
	input  logic                                    active,
	output ssms_pkg::side_t                         side
);
	import ssms_pkg::*;

	logic signed [COORD_W-1:0] ax [3][3];
	logic                      axis_zero [3];

	logic signed [DIFF_W-1:0]  d_s1 [3];
	logic                      vld_s1;

	logic signed [40:0]        prod_s2 [3][3];
	logic [SQ_W-1:0]           asq_s2 [3][3];
	logic [DD_W-1:0]           dsq_s2 [3];
	logic                      vld_s2;

	logic signed [MD_W-1:0]    dot_s3 [3];
	logic [SQ_W-1:0]           sq_s3 [3];
	logic [DD_W-1:0]           dd_s3;
	logic                      fault_s3;
	logic                      vld_s3;

	// unpack axis coordinates
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				ax[k][i] = axis[k][i*COORD_W +: COORD_W];
			end
			axis_zero[k] = (axis[k] == '0);
		end
	end

	// stage 1: point minus origin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DIFF_W'(signed'(point[i*COORD_W +: COORD_W]))
					- DIFF_W'(signed'(origin[i*COORD_W +: COORD_W]));
			end
		end
	end

	// stage 2: all products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [40:0] sq_tmp;
		logic signed [41:0] dd_tmp;
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s2[k][i] <= 41'(d_s1[i]) * 41'(ax[k][i]);
					sq_tmp         = 41'(ax[k][i]) * 41'(ax[k][i]);
					asq_s2[k][i]  <= sq_tmp[SQ_W-1:0];
				end
				dd_tmp     = 42'(d_s1[k]) * 42'(d_s1[k]);
				dsq_s2[k] <= dd_tmp[DD_W-1:0];
			end
		end
	end

	// stage 3: sums and fault
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dot_s3[k] <= MD_W'(prod_s2[k][0]) + MD_W'(prod_s2[k][1])
					+ MD_W'(prod_s2[k][2]);
				sq_s3[k]  <= asq_s2[k][0] + asq_s2[k][1] + asq_s2[k][2];
			end
			dd_s3    <= dsq_s2[0] + dsq_s2[1] + dsq_s2[2];
			fault_s3 <= active && (axis_zero[0] || axis_zero[1] || axis_zero[2]);
		end
	end

	// stage 4: magnitudes and compare against squared length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side <= '0;
		end else if (en) begin
			side.vld   <= vld_s3;
			side.fault <= fault_s3;
			side.big   <= 1'b0;
			side.dd    <= dd_s3;
			side.m     <= '0;
			side.root  <= '0;
			for (int k = 0; k < 3; k++) begin
				side.md[k] <= dot_s3[k][MD_W-1] ? MD_W'(-dot_s3[k]) : MD_W'(dot_s3[k]);
				side.sq[k] <= sq_s3[k];
				side.gt[k] <= (dot_s3[k][MD_W-1] ? MD_W'(-dot_s3[k]) : MD_W'(dot_s3[k]))
					> {3'd0, sq_s3[k]};
			end
		end
	end

endmodule

@@ rtl/solid_source_mesh_size_core.sv @@
// top level: mesh size around a cuboid or ellipsoid source, one point per cycle
//
// channel  | signals                         | contents
// s_axis   | s_tvalid s_tready s_tdata[63:0] | query point
// m_axis   | m_tvalid m_tready m_tdata m_tuser | mesh size and axis fault
// config   | cfg_we cfg_index cfg_data       | register writes, no read-back
//
// one point enters per cycle unless stalled; each passes the front stages,
// two rounds of 32-stage square root and 32-stage divide, and output stages.
// arst_n clears all valid bits and loads the register reset values.
// when the output holds an unaccepted result the whole pipeline stalls in
// place, so nothing is dropped or repeated.
module solid_source_mesh_size_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// x bits 19:0, y bits 39:20, z bits 59:40, zero above
	input  logic [63:0]                         s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// mesh_size bits 31:0
	output logic [31:0]                         m_tdata,
	// axis_fault bit 0
	output logic                                m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_we,
	input  logic [ssms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssms_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ssms_pkg::*;

	logic [1:0]             mode_q;
	logic [PACK_W-1:0]      origin_q;
	logic [2:0][PACK_W-1:0] axis_q;
	logic [30:0]            base_q;
	logic [15:0]            growth_q;

	logic en;
	logic active;
	logic cuboid;

	side_t side1;
	side_t side2;
	side_t side2m;
	side_t side3;
	side_t side5;
	side_t side5r;
	side_t side6;
	side_t tag_s2b;
	side_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	logic [31:0] len    [3];
	logic [31:0] m_root;
	logic [63:0] dnum   [3];
	logic [47:0] dden   [3];
	logic [31:0] quo    [3];
	logic        ovf    [3];
	logic [30:0] val_s1 [3];
	logic [61:0] sqv_s2 [3];
	logic [63:0] acc_s3;
	logic [31:0] root5;
	logic [31:0] fq;
	logic        fovf;
	logic [42:0] fm_s4;
	logic [31:0] len_s5;
	logic [47:0] prod_s6;
	logic [15:0] gm;
	logic signed [37:0] total;

	function automatic logic acc_next_big(input logic [61:0] a, input logic [61:0] b,
		input logic [61:0] c);
		logic [63:0] sum;
		sum = 64'(a) + 64'(b) + 64'(c);
		return sum > 64'h4000_0000;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SURFACE;
			origin_q <= '0;
			axis_q   <= '0;
			base_q   <= '0;
			growth_q <= GROWTH_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q    <= cfg_data[1:0];
				REG_ORIGIN: origin_q  <= cfg_data[PACK_W-1:0];
				REG_AXIS_A: axis_q[0] <= cfg_data[PACK_W-1:0];
				REG_AXIS_B: axis_q[1] <= cfg_data[PACK_W-1:0];
				REG_AXIS_C: axis_q[2] <= cfg_data[PACK_W-1:0];
				REG_BASE:   base_q    <= cfg_data[30:0];
				REG_GROWTH: growth_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign active   = (mode_q == MODE_CUBOID) || (mode_q == MODE_ELLIPSOID);
	assign cuboid   = (mode_q == MODE_CUBOID);
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// front stages
	ssms_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (s_tvalid),
		.point  (s_tdata[PACK_W-1:0]),
		.origin (origin_q),
		.axis   (axis_q),
		.active (active),
		.side   (side1)
	);

	// axis lengths for cuboid mode and distance from origin
	ssms_isqrt u_len0 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.op ({2'd0, side1.sq[0], 22'd0}), .tag_in (side1),
		.root (len[0]), .tag_out (side2)
	);
	ssms_isqrt u_len1 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.op ({2'd0, side1.sq[1], 22'd0}), .tag_in ('0),
		.root (len[1]), .tag_out ()
	);
	ssms_isqrt u_len2 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.op ({2'd0, side1.sq[2], 22'd0}), .tag_in ('0),
		.root (len[2]), .tag_out ()
	);
	ssms_isqrt u_dist (
		.clk (clk), .arst_n (arst_n), .en (en),
		.op ({10'd0, side1.dd, 12'd0}), .tag_in ('0),
		.root (m_root), .tag_out ()
	);

	// per-axis division operands
	always_comb begin
		side2m   = side2;
		side2m.m = m_root;
		for (int k = 0; k < 3; k++) begin
			if (cuboid) begin
				dnum[k] = {4'd0, side2.md[k] - {3'd0, side2.sq[k]}, 17'd0};
				dden[k] = {16'd0, len[k]};
			end else begin
				dnum[k] = {5'd0, side2.md[k], 16'd0};
				dden[k] = {8'd0, side2.sq[k]};
			end
		end
	end

	ssms_div u_div0 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.num (dnum[0]), .den (dden[0]), .tag_in (side2m),
		.quo (quo[0]), .ovf (ovf[0]), .tag_out (side3)
	);
	ssms_div u_div1 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.num (dnum[1]), .den (dden[1]), .tag_in ('0),
		.quo (quo[1]), .ovf (ovf[1]), .tag_out ()
	);
	ssms_div u_div2 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.num (dnum[2]), .den (dden[2]), .tag_in ('0),
		.quo (quo[2]), .ovf (ovf[2]), .tag_out ()
	);

	// flag the ellipsoid sum against one
	always_comb begin
		tag_s2b     = tag_s2;
		tag_s2b.big = acc_next_big(sqv_s2[0], sqv_s2[1], sqv_s2[2]);
	end

	// side data registers for the short stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
		end else if (en) begin
			tag_s1 <= side3;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2b;
			tag_s4 <= side6;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
		end
	end

	// saturate quotients, square, and sum
	always_ff @(posedge clk) begin
		logic [61:0] sq_tmp;
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (cuboid) begin
					if (!side3.gt[k]) begin
						val_s1[k] <= '0;
					end else if (ovf[k] || quo[k] > 32'h4000_0000) begin
						val_s1[k] <= 31'h4000_0000;
					end else begin
						val_s1[k] <= quo[k][30:0];
					end
				end else begin
					val_s1[k] <= (ovf[k] || quo[k][31]) ? 31'h7FFF_FFFF : quo[k][30:0];
				end
				sq_tmp     = 62'(val_s1[k]) * 62'(val_s1[k]);
				sqv_s2[k] <= cuboid ? sq_tmp : sq_tmp >> 2;
			end
			acc_s3 <= 64'(sqv_s2[0]) + 64'(sqv_s2[1]) + 64'(sqv_s2[2]);
		end
	end

	// root of the sum: cuboid length or ellipsoid scale
	ssms_isqrt u_root (
		.clk (clk), .arst_n (arst_n), .en (en),
		.op (acc_s3), .tag_in (tag_s3),
		.root (root5), .tag_out (side5)
	);

	always_comb begin
		side5r      = side5;
		side5r.root = root5;
	end

	// ellipsoid shrink factor
	ssms_div u_fdiv (
		.clk (clk), .arst_n (arst_n), .en (en),
		.num ({16'd0, root5 - 32'd32768, 16'd0}), .den ({16'd0, root5}),
		.tag_in (side5r),
		.quo (fq), .ovf (fovf), .tag_out (side6)
	);

	assign gm = (growth_q >= GROWTH_ONE) ? growth_q - GROWTH_ONE : GROWTH_ONE - growth_q;

	// length selection and growth product
	always_ff @(posedge clk) begin
		if (en) begin
			fm_s4 <= fovf ? '0 : 43'(fq[15:0]) * 43'(side6.m[26:0]);
			if (!active || tag_s4.fault) begin
				len_s5 <= '0;
			end else if (cuboid) begin
				len_s5 <= tag_s4.root;
			end else if (tag_s4.big) begin
				len_s5 <= {5'd0, fm_s4[42:16]};
			end else begin
				len_s5 <= '0;
			end
			prod_s6 <= 48'(gm) * 48'(len_s5);
		end
	end

	// add to or subtract from base size; the output register saturates
	always_comb begin
		if (growth_q < GROWTH_ONE) begin
			total = 38'(signed'({7'd0, base_q})) - 38'(signed'({2'd0, prod_s6[47:12]}));
		end else begin
			total = 38'(signed'({7'd0, base_q})) + 38'(signed'({2'd0, prod_s6[47:12]}));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= tag_s6.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (total > 38'sh0_7FFF_FFFF) begin
				m_tdata <= 32'h7FFF_FFFF;
			end else if (total < -38'sh0_8000_0000) begin
				m_tdata <= 32'h8000_0000;
			end else begin
				m_tdata <= total[31:0];
			end
			m_tuser <= tag_s6.fault;
		end
	end

endmodule
